@@ hw/rtl/tlpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_pkg: shared types and constants of the length-table packet deframer
// Opcodes, table entry layout, table write request and result word layout.
// ----------------------------------------------------------------------------
package tlpd_pkg;

	localparam int ID_W  = 16;
	localparam int LEN_W = 16;

	// Kind of input word, carried on s_tuser
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [LEN_W-1:0] MIN_FIXED_LEN = 16'd2;
	localparam logic [LEN_W-1:0] MIN_VAR_LEN   = 16'd4;

	// Packet positions with their own meaning
	localparam logic [LEN_W-1:0] POS_ID_LO  = 16'd0;
	localparam logic [LEN_W-1:0] POS_ID_HI  = 16'd1;
	localparam logic [LEN_W-1:0] POS_LEN_LO = 16'd2;
	localparam logic [LEN_W-1:0] POS_LEN_HI = 16'd3;

	// Bit 16 = variable, bits 15..0 = fixed length; all zero means unknown id
	typedef struct packed {
		logic             variable;
		logic [LEN_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic            en;
		logic [ID_W-1:0] addr;
		entry_t          data;
	} tbl_wr_t;

	typedef struct packed {
		logic            length_error;
		logic [ID_W-1:0] packet_id;
		logic            packet_last;
		logic            packet_first;
		logic [7:0]      out_byte;
	} result_t;

endpackage

@@ hw/rtl/tlpd_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_table: packet length table
// Synchronous RAM with one write and one registered read port, swept to zero
// after reset.
// ----------------------------------------------------------------------------
module tlpd_table #(
	parameter int TABLE_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tlpd_pkg::tbl_wr_t       wr,
	input  logic                    rd_en,
	input  logic [TABLE_BITS-1:0]   rd_addr,
	output tlpd_pkg::entry_t        rd_data,
	output logic                    busy
);
	import tlpd_pkg::*;

	localparam int DEPTH = 2 ** TABLE_BITS;

	entry_t                mem [DEPTH];
	logic [TABLE_BITS-1:0] clr_addr_q;
	logic                  busy_q;
	logic                  we;
	logic [TABLE_BITS-1:0] waddr;
	entry_t                wdata;

	// clearing sweep owns the write port until it finishes
	always_comb begin
		if (busy_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = wr.en;
			waddr = wr.addr[TABLE_BITS-1:0];
			wdata = wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

@@ hw/rtl/tlpd_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_track: packet position tracker
// Holds the per-packet state and marks each byte with first, last, id and
// length error.
// ----------------------------------------------------------------------------
module tlpd_track (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [7:0]         byte_in,
	input  tlpd_pkg::entry_t   entry,
	output tlpd_pkg::result_t  res
);
	import tlpd_pkg::*;

	logic [LEN_W-1:0] pos_q, pos_d;
	logic [LEN_W-1:0] exp_len_q, exp_len_d;
	logic [7:0]       id_lo_q, id_lo_d;
	logic [ID_W-1:0]  cur_id_q, cur_id_d;
	logic             is_var_q, is_var_d;
	logic [7:0]       len_lo_q, len_lo_d;
	logic             err_q, err_d;
	logic [LEN_W-1:0] len;
	logic             first, last;
	logic [ID_W-1:0]  id;

	always_comb begin
		pos_d     = pos_q;
		exp_len_d = exp_len_q;
		id_lo_d   = id_lo_q;
		cur_id_d  = cur_id_q;
		is_var_d  = is_var_q;
		len_lo_d  = len_lo_q;
		err_d     = err_q;
		len       = exp_len_q;
		first     = 1'b0;
		last      = 1'b0;
		id        = '0;

		if (pos_q == POS_ID_LO) begin
			first   = 1'b1;
			id_lo_d = byte_in;
			err_d   = 1'b0;
			pos_d   = POS_ID_HI;
		end else if (pos_q == POS_ID_HI) begin
			cur_id_d = {byte_in, id_lo_q};
			id       = cur_id_d;
			if (entry.variable) begin
				is_var_d  = 1'b1;
				exp_len_d = '0;
				pos_d     = POS_LEN_LO;
			end else begin
				is_var_d = 1'b0;
				len      = entry.length;
				if (len == '0) begin
					len = MIN_FIXED_LEN;
				end else if (len < MIN_FIXED_LEN) begin
					len   = MIN_FIXED_LEN;
					err_d = 1'b1;
				end
				exp_len_d = len;
				if (len == MIN_FIXED_LEN) begin
					last = 1'b1;
				end else begin
					pos_d = POS_LEN_LO;
				end
			end
		end else begin
			id = cur_id_q;
			if (is_var_q && pos_q == POS_LEN_LO) begin
				len_lo_d = byte_in;
				pos_d    = POS_LEN_HI;
			end else begin
				if (is_var_q && pos_q == POS_LEN_HI) begin
					len = {byte_in, len_lo_q};
					if (len < MIN_VAR_LEN) begin
						len   = MIN_VAR_LEN;
						err_d = 1'b1;
					end
					exp_len_d = len;
				end
				if ({1'b0, pos_q} + 17'd1 >= {1'b0, len}) begin
					last = 1'b1;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
		end

		res.out_byte     = byte_in;
		res.packet_first = first;
		res.packet_last  = last;
		res.packet_id    = id;
		res.length_error = err_d;

		// close the packet
		if (last) begin
			pos_d     = POS_ID_LO;
			exp_len_d = '0;
			is_var_d  = 1'b0;
			err_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			exp_len_q <= '0;
			id_lo_q   <= '0;
			cur_id_q  <= '0;
			is_var_q  <= 1'b0;
			len_lo_q  <= '0;
			err_q     <= 1'b0;
		end else if (adv) begin
			pos_q     <= pos_d;
			exp_len_q <= exp_len_d;
			id_lo_q   <= id_lo_d;
			cur_id_q  <= cur_id_d;
			is_var_q  <= is_var_d;
			len_lo_q  <= len_lo_d;
			err_q     <= err_d;
		end
	end

endmodule

@@ hw/rtl/table_length_packet_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_length_packet_deframer: cut a byte stream into table-sized packets
// Looks up the length of each packet by its 16-bit id and marks every byte.
// ----------------------------------------------------------------------------
// Usage
//  Slave side (s_*): one word per byte of the stream, or a table write.
//    s_tuser selects the kind: stream byte or length table write.
//  Master side (m_*): one word per stream byte; table writes give none.
//    m_tlast marks the last byte of a packet, m_tuser carries the first
//    mark and the length error flag, m_tdata the byte and the packet id.
//  Path: an accepted byte waits in the first stage for its table read, then
//    moves to the output register.
//  Throughput: one word per cycle while m_tready is high and no sweep runs.
//    The table read for the id is issued speculatively with every byte from
//    the previous byte and this one, so the lookup does not hold the stream.
//  Reset: all packet state clears at once; the length table is then swept to
//    zero, one entry per cycle, over all 2**TABLE_BITS entries (4096 by
//    default), with s_tready held low until the sweep is done.
//  Stall: when m_tready is low the output register holds its word, the
//    stage behind it fills, and then s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module table_length_packet_deframer #(
	parameter int TABLE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // stream_byte, entry_index, entry_length, entry_variable, zero pad
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte, packet_id
	output logic [1:0]  m_tuser,   // packet_first, length_error
	output logic        m_tlast    // packet_last
);
	import tlpd_pkg::*;

	// input word fields
	logic [7:0]       in_byte;
	logic [11:0]      in_index;
	logic [LEN_W-1:0] in_length;
	logic             in_variable;

	logic             accept;
	logic             busy;
	logic [7:0]       last_byte_q;
	logic [ID_W-1:0]  rd_id;
	logic             rd_in_range;
	logic             wr_in_range;
	tbl_wr_t          wr;
	entry_t           rd_data;
	entry_t           entry;

	logic             s1_valid_q;
	logic [7:0]       byte_s1;
	logic             in_range_s1;
	logic             s1_adv;

	result_t          res;
	result_t          out_q;
	logic             m_valid_q;

	assign in_byte     = s_tdata[7:0];
	assign in_index    = s_tdata[19:8];
	assign in_length   = s_tdata[35:20];
	assign in_variable = s_tdata[36];

	// Advance the first stage when the output register is free or being taken
	assign s1_adv   = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !busy && (!s1_valid_q || s1_adv);
	assign accept   = s_tvalid && s_tready;

	// Speculative id: previous stream byte low, this byte high. It is only
	// used when the tracker finds this byte at the second packet position.
	assign rd_id       = {in_byte, last_byte_q};
	assign rd_in_range = ((32'(rd_id) >> TABLE_BITS) == 32'd0);
	assign wr_in_range = ((32'(in_index) >> TABLE_BITS) == 32'd0);

	// Drop table writes whose index lies beyond the table
	always_comb begin
		wr.en   = accept && (s_tuser == OP_WRITE) && wr_in_range;
		wr.addr = ID_W'(in_index);
		wr.data = '{variable: in_variable, length: in_length};
	end

	tlpd_table #(
		.TABLE_BITS(TABLE_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (accept && (s_tuser == OP_BYTE)),
		.rd_addr (rd_id[TABLE_BITS-1:0]),
		.rd_data (rd_data),
		.busy    (busy)
	);

	// First stage: stream byte waiting on its table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			last_byte_q <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= (s_tuser == OP_BYTE);
				if (s_tuser == OP_BYTE) begin
					last_byte_q <= in_byte;
				end
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (s_tuser == OP_BYTE)) begin
			byte_s1     <= in_byte;
			in_range_s1 <= rd_in_range;
		end
	end

	// Ids beyond the table read as unknown
	assign entry = in_range_s1 ? rd_data : '0;

	tlpd_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (s1_adv),
		.byte_in (byte_s1),
		.entry   (entry),
		.res     (res)
	);

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_q.packet_id, out_q.out_byte};
	assign m_tuser  = {out_q.length_error, out_q.packet_first};
	assign m_tlast  = out_q.packet_last;

	// No word is taken while the table is being swept
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("input accepted during table sweep");

	// A packet is at least two bytes, so first and last never coincide
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tlast))
		else $error("packet of one byte emitted");

	// The length is unknown on the first byte, so no error can be flagged
	a_no_err_on_first: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> !m_tuser[1])
		else $error("length error on first byte");

	// A stalled first stage keeps its byte
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(byte_s1)))
		else $error("first stage lost a byte while stalled");

endmodule
